>>> rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// shared constants, state encoding and control/status bundles for the
// longest complementary substring block
// ----------------------------------------------------------------------------
`default_nettype none

package lcs_pkg;

	localparam int MAX_LEN = 256;
	localparam int IDX_W   = $clog2(MAX_LEN);
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int LEN_W   = $clog2(MAX_LEN + 1);

	localparam logic CMD_FIRST  = 1'b0;
	localparam logic CMD_SECOND = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic load_first;
		logic begin_second;
		logic sweep;
		logic report;
	} ctrl_t;

	typedef struct packed {
		logic first_empty;
		logic second_full;
		logic sweep_done;
	} status_t;

endpackage

`default_nettype wire

>>> rtl/lcs_ctrl.sv
// ----------------------------------------------------------------------------
// lcs_ctrl
// beat acceptance and sequencing of load, sweep and report phases
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            command,
	input  wire logic            last,
	input  wire lcs_pkg::status_t status,
	output logic                 busy,
	output lcs_pkg::ctrl_t       ctrl
);

	lcs_pkg::state_t state_q;
	lcs_pkg::state_t state_d;
	logic            last_q;
	logic            accept;

	assign accept = start && (state_q == lcs_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcs_pkg::ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_q <= last;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcs_pkg::ST_IDLE: begin
				if (accept && command == lcs_pkg::CMD_SECOND) begin
					if (!status.second_full && !status.first_empty) begin
						state_d = lcs_pkg::ST_SWEEP;
					end else if (last) begin
						state_d = lcs_pkg::ST_REPORT;
					end
				end
			end
			lcs_pkg::ST_SWEEP: begin
				if (status.sweep_done) begin
					state_d = last_q ? lcs_pkg::ST_REPORT : lcs_pkg::ST_IDLE;
				end
			end
			lcs_pkg::ST_REPORT: begin
				state_d = lcs_pkg::ST_IDLE;
			end
			default: begin
				state_d = lcs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy              = (state_q != lcs_pkg::ST_IDLE);
		ctrl.load_first   = accept && (command == lcs_pkg::CMD_FIRST);
		ctrl.begin_second = accept && (command == lcs_pkg::CMD_SECOND);
		ctrl.sweep        = (state_q == lcs_pkg::ST_SWEEP);
		ctrl.report       = (state_q == lcs_pkg::ST_REPORT);
	end

endmodule

`default_nettype wire

>>> rtl/lcs_dpath.sv
// ----------------------------------------------------------------------------
// lcs_dpath
// base and run-length stores, one-entry-per-cycle run update and best
// tracking, registered result
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_dpath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire lcs_pkg::ctrl_t               ctrl,
	input  wire logic [1:0]                   base,
	input  wire logic                         blocked,
	output lcs_pkg::status_t                  status,
	output logic                              done,
	output logic                              found,
	output logic [lcs_pkg::LEN_W-1:0]         match_length,
	output logic [7:0]                        start_first,
	output logic [7:0]                        end_first,
	output logic [7:0]                        start_second,
	output logic [7:0]                        end_second
);

	localparam logic [lcs_pkg::LEN_W:0] SAT = (lcs_pkg::LEN_W + 1)'(lcs_pkg::MAX_LEN);
	localparam logic [lcs_pkg::CNT_W-1:0] FULL = lcs_pkg::CNT_W'(lcs_pkg::MAX_LEN);

	logic [2:0]                base_mem [lcs_pkg::MAX_LEN];
	logic [lcs_pkg::LEN_W-1:0] run_mem  [lcs_pkg::MAX_LEN];

	logic [lcs_pkg::CNT_W-1:0] count_q;
	logic [lcs_pkg::CNT_W-1:0] pos_q;
	logic [lcs_pkg::CNT_W-1:0] idx_q;
	logic [lcs_pkg::IDX_W-1:0] j_q;
	logic [1:0]                base_q;
	logic                      blk_q;
	logic [lcs_pkg::LEN_W-1:0] prev_q;
	logic [lcs_pkg::LEN_W-1:0] best_q;
	logic [lcs_pkg::IDX_W-1:0] best_ef_q;
	logic [lcs_pkg::IDX_W-1:0] best_es_q;

	logic                      valid_s1;
	logic [lcs_pkg::IDX_W-1:0] idx_s1;
	logic [2:0]                base_rd_s1;
	logic [lcs_pkg::LEN_W-1:0] run_rd_s1;

	logic                      rd_en;
	logic                      store_first;
	logic                      hit;
	logic [lcs_pkg::LEN_W:0]   sum;
	logic [lcs_pkg::LEN_W-1:0] v;
	logic                      better;

	assign store_first = ctrl.load_first && (count_q != FULL);
	assign rd_en       = ctrl.sweep && (idx_q != count_q);

	assign hit = !blk_q && !base_rd_s1[2] && (base_rd_s1[1:0] == ~base_q);
	assign sum = {1'b0, prev_q} + (lcs_pkg::LEN_W + 1)'(1);
	always_comb begin
		v = '0;
		if (hit) begin
			v = (sum > SAT) ? SAT[lcs_pkg::LEN_W-1:0] : sum[lcs_pkg::LEN_W-1:0];
		end
	end
	assign better = (v > best_q) || ((v != '0) && (v == best_q) && (idx_s1 < best_ef_q));

	assign status.first_empty = (count_q == '0);
	assign status.second_full = (pos_q == FULL);
	assign status.sweep_done  = (idx_q == count_q) && !valid_s1;

	// stores
	always_ff @(posedge clk) begin
		if (store_first) begin
			base_mem[count_q[lcs_pkg::IDX_W-1:0]] <= {blocked, base};
		end
		if (store_first) begin
			run_mem[count_q[lcs_pkg::IDX_W-1:0]] <= '0;
		end else if (valid_s1) begin
			run_mem[idx_s1] <= v;
		end
		if (rd_en) begin
			base_rd_s1 <= base_mem[idx_q[lcs_pkg::IDX_W-1:0]];
			run_rd_s1  <= run_mem[idx_q[lcs_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= idx_q[lcs_pkg::IDX_W-1:0];
		end
		if (ctrl.begin_second) begin
			base_q <= base;
			blk_q  <= blocked;
			j_q    <= pos_q[lcs_pkg::IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pos_q     <= '0;
			idx_q     <= '0;
			prev_q    <= '0;
			best_q    <= '0;
			best_ef_q <= '0;
			best_es_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			if (store_first) begin
				count_q <= count_q + lcs_pkg::CNT_W'(1);
			end
			if (ctrl.begin_second) begin
				idx_q  <= '0;
				prev_q <= '0;
				if (pos_q != FULL) begin
					pos_q <= pos_q + lcs_pkg::CNT_W'(1);
				end
			end
			if (rd_en) begin
				idx_q <= idx_q + lcs_pkg::CNT_W'(1);
			end
			if (valid_s1) begin
				prev_q <= run_rd_s1;
				if (better) begin
					best_q    <= v;
					best_ef_q <= idx_s1;
					best_es_q <= j_q;
				end
			end
			if (ctrl.report) begin
				count_q   <= '0;
				pos_q     <= '0;
				best_q    <= '0;
				best_ef_q <= '0;
				best_es_q <= '0;
			end
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctrl.report;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.report) begin
			found        <= (best_q != '0);
			match_length <= best_q;
			end_first    <= best_ef_q;
			end_second   <= best_es_q;
			if (best_q != '0) begin
				start_first  <= 8'(best_ef_q - best_q[7:0] + 8'd1);
				start_second <= 8'(best_es_q - best_q[7:0] + 8'd1);
			end else begin
				start_first  <= '0;
				start_second <= '0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/longest_complementary_substring.sv
// ----------------------------------------------------------------------------
// longest_complementary_substring
// first-string beat: busy stays low. second-string beat: busy while the run
// store is swept one entry per cycle through its registered read port, then
// drained; no sweep if the first string is empty or the second is full
// a second-string beat with last set adds a report state; done pulses the cycle
// after it, the receiver cannot stall it
// arst_n clears control, counts and best run; stores need no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module longest_complementary_substring (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         command,
	input  wire logic [1:0]                   base,
	input  wire logic                         blocked,
	input  wire logic                         last,
	output logic                              done,
	output logic                              found,
	output logic [lcs_pkg::LEN_W-1:0]         match_length,
	output logic [7:0]                        start_first,
	output logic [7:0]                        end_first,
	output logic [7:0]                        start_second,
	output logic [7:0]                        end_second
);

	lcs_pkg::ctrl_t   ctrl;
	lcs_pkg::status_t status;

	lcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(command),
		.last   (last),
		.status (status),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	lcs_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.base        (base),
		.blocked     (blocked),
		.status      (status),
		.done        (done),
		.found       (found),
		.match_length(match_length),
		.start_first (start_first),
		.end_first   (end_first),
		.start_second(start_second),
		.end_second  (end_second)
	);

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result beat while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beat repeated");
	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (found == (match_length != '0))) else $error("found disagrees with length");
	a_first_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == lcs_pkg::CMD_FIRST) |=> !busy)
		else $error("first-string beat made block busy");
`endif

endmodule

`default_nettype wire
